### sv/bounded_array_list_engine_unit_assert.svh
// Assertion macros for the array list engine.
// Both sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef BOUNDED_ARRAY_LIST_ENGINE_UNIT_ASSERT_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BALE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BALE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/bale_pkg.sv
`default_nettype none

package bale_pkg;

    // Operation codes carried in the func field.
    typedef enum logic [2:0] {
        FN_INSERT,
        FN_APPEND,
        FN_EXTRACT,
        FN_CLEAR,
        FN_COUNT,
        FN_INDEX,
        FN_REVERSE,
        FN_LENGTH
    } bale_func_t;

    // Status codes returned with every result.
    typedef enum logic [2:0] {
        ST_OK,
        ST_FULL,
        ST_BADPOS,
        ST_EMPTY,
        ST_NOTFOUND
    } bale_status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_SHIFT_DOWN,
        S_SCAN,
        S_REV_LO,
        S_REV_HI,
        S_REV_WR,
        S_FINISH
    } bale_state_t;

    // One request as taken from the request channel.
    typedef struct packed {
        bale_func_t         func;
        logic signed [31:0] item_value;
        logic [3:0]         position;
    } bale_req_t;

    // One result as handed to the response channel.
    typedef struct packed {
        bale_status_t       status;
        logic signed [31:0] read_value;
        logic [2:0]         found_index;
        logic [3:0]         match_count;
        logic [3:0]         list_length;
    } bale_result_t;

endpackage

`default_nettype wire

### sv/bale_ifs.sv
`default_nettype none

// Request channel: one list operation per transaction.
interface bale_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [31:0] item_value;
    logic [3:0]         position;

    modport source (output valid, output func, output item_value, output position,
                    input ready);
    modport sink (input valid, input func, input item_value, input position,
                  output ready);
endinterface

// Response channel: one result per request.
interface bale_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] read_value;
    logic [2:0]         found_index;
    logic [3:0]         match_count;
    logic [3:0]         list_length;

    modport source (output valid, output status, output read_value, output found_index,
                    output match_count, output list_length, input ready);
    modport sink (input valid, input status, input read_value, input found_index,
                  input match_count, input list_length, output ready);
endinterface

`default_nettype wire

### sv/bale_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module bale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read; a read of the address being written returns the old word.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/bale_ctrl.sv
`default_nettype none

// Operation sequencer: walks the entry memory with at most one read and one
// write per cycle to shift, scan and reverse the list.
module bale_ctrl
    import bale_pkg::*;
#(
    parameter int CAPACITY = 8
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire bale_req_t                req,
    input  wire logic                     req_valid,
    output logic                          req_ready,
    output bale_result_t                  res,
    output logic                          res_valid,
    input  wire logic                     res_ready,
    output logic                          mem_we,
    output logic [$clog2(CAPACITY > 1 ? CAPACITY : 2)-1:0] mem_waddr,
    output logic [31:0]                   mem_wdata,
    output logic                          mem_re,
    output logic [$clog2(CAPACITY > 1 ? CAPACITY : 2)-1:0] mem_raddr,
    input  wire logic [31:0]              mem_rdata
);

    localparam int AW = $clog2(CAPACITY > 1 ? CAPACITY : 2);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > 4) ? LW : 4;
    localparam int FW = (AW > 3) ? AW : 3;

    bale_state_t   state_reg, state_next;
    bale_state_t   start_state;
    bale_status_t  start_status;
    bale_status_t  status_reg, status_next;
    bale_func_t    op_reg, op_next;
    logic [LW-1:0] len_reg, len_next;
    logic [31:0]   val_reg, val_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [LW-1:0] ptr_reg, ptr_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] lo_reg, lo_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic [AW-1:0] whi_reg, whi_next;
    logic          wpend_reg, wpend_next;
    logic [31:0]   tmp_reg, tmp_next;
    logic          hit_reg, hit_next;
    logic [AW-1:0] fidx_reg, fidx_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic [31:0]   rd_reg, rd_next;

    logic          req_fire;
    logic [CW-1:0] pos_in;
    logic [CW-1:0] len_c;
    logic [CW-1:0] cnt_c;
    logic [FW-1:0] fidx_c;
    logic [LW-1:0] len_m1;
    logic [LW-1:0] ptr_m1;
    logic [LW-1:0] ptr_m2;
    logic [LW-1:0] ptr_p1;
    logic [LW-1:0] up_target;
    logic [LW-1:0] up_src;
    logic          len_full;
    logic          len_zero;
    logic          up_done;
    logic          walk_done;
    logic          rev_more;

    // Shared arithmetic on the pointers and the length.
    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign pos_in    = CW'(req.position);
    assign len_c     = CW'(len_reg);
    assign cnt_c     = CW'(cnt_reg);
    assign fidx_c    = FW'(fidx_reg);
    assign len_m1    = len_reg - LW'(1);
    assign ptr_m1    = ptr_reg - LW'(1);
    assign ptr_m2    = ptr_reg - LW'(2);
    assign ptr_p1    = ptr_reg + LW'(1);
    assign up_target = pend_reg ? ptr_m1 : ptr_reg;
    assign up_src    = up_target - LW'(1);
    assign len_full  = (len_reg == LW'(CAPACITY));
    assign len_zero  = (len_reg == '0);
    assign up_done   = !pend_reg && (CW'(ptr_reg) == pos_reg);
    assign walk_done = !pend_reg && !(ptr_reg < len_reg);
    assign rev_more  = (lo_reg < hi_reg);

    // Request decode: error checks and the first state of each operation.
    always_comb
    begin
        start_state  = S_FINISH;
        start_status = ST_OK;
        case (req.func)
            FN_INSERT:
            begin
                if (len_full)
                begin
                    start_status = ST_FULL;
                end
                else if (pos_in > len_c)
                begin
                    start_status = ST_BADPOS;
                end
                else
                begin
                    start_state = S_SHIFT_UP;
                end
            end
            FN_APPEND:
            begin
                if (len_full)
                begin
                    start_status = ST_FULL;
                end
                else
                begin
                    start_state = S_SHIFT_UP;
                end
            end
            FN_EXTRACT:
            begin
                if (len_zero)
                begin
                    start_status = ST_EMPTY;
                end
                else if (!(pos_in < len_c))
                begin
                    start_status = ST_BADPOS;
                end
                else
                begin
                    start_state = S_SHIFT_DOWN;
                end
            end
            FN_COUNT, FN_INDEX:
            begin
                if (len_zero)
                begin
                    start_status = ST_EMPTY;
                end
                else
                begin
                    start_state = S_SCAN;
                end
            end
            FN_REVERSE:
            begin
                if (len_zero)
                begin
                    start_status = ST_EMPTY;
                end
                else
                begin
                    start_state = S_REV_LO;
                end
            end
            default:
            begin
                start_state  = S_FINISH;
                start_status = ST_OK;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = start_state;
                end
            end
            S_SHIFT_UP:
            begin
                if (up_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT_DOWN, S_SCAN:
            begin
                if (walk_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_REV_LO:
            begin
                state_next = rev_more ? S_REV_HI : S_FINISH;
            end
            S_REV_HI:
            begin
                state_next = S_REV_WR;
            end
            S_REV_WR:
            begin
                state_next = S_REV_LO;
            end
            S_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory port control for each state.
    always_comb
    begin
        status_next = status_reg;
        op_next     = op_reg;
        len_next    = len_reg;
        val_next    = val_reg;
        pos_next    = pos_reg;
        ptr_next    = ptr_reg;
        pend_next   = pend_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        whi_next    = whi_reg;
        wpend_next  = wpend_reg;
        tmp_next    = tmp_reg;
        hit_next    = hit_reg;
        fidx_next   = fidx_reg;
        cnt_next    = cnt_reg;
        rd_next     = rd_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        res_valid   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next     = req.func;
                    val_next    = req.item_value;
                    status_next = start_status;
                    rd_next     = '0;
                    cnt_next    = '0;
                    fidx_next   = '0;
                    hit_next    = 1'b0;
                    pend_next   = 1'b0;
                    wpend_next  = 1'b0;
                    lo_next     = '0;
                    hi_next     = len_m1[AW-1:0];
                    pos_next    = (req.func == FN_APPEND) ? len_c : pos_in;
                    case (req.func)
                        FN_EXTRACT:        ptr_next = pos_in[LW-1:0];
                        FN_COUNT, FN_INDEX: ptr_next = '0;
                        default:           ptr_next = len_reg;
                    endcase
                    if (req.func == FN_CLEAR)
                    begin
                        len_next = '0;
                    end
                end
            end

            // Move entries up one place from the tail down to the insert point,
            // then drop the new value in.
            S_SHIFT_UP:
            begin
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ptr_reg[AW-1:0];
                    mem_wdata = mem_rdata;
                end
                else if (up_done)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ptr_reg[AW-1:0];
                    mem_wdata = val_reg;
                    len_next  = len_reg + LW'(1);
                end
                ptr_next = up_target;
                if (CW'(up_target) > pos_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = up_src[AW-1:0];
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            // Read the extracted entry, then move each later entry down one place.
            S_SHIFT_DOWN:
            begin
                if (pend_reg)
                begin
                    if (CW'(ptr_m1) == pos_reg)
                    begin
                        rd_next = mem_rdata;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = ptr_m2[AW-1:0];
                        mem_wdata = mem_rdata;
                    end
                end
                if (ptr_reg < len_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg[AW-1:0];
                    ptr_next  = ptr_p1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (walk_done)
                begin
                    len_next = len_m1;
                end
            end

            // Compare every held entry with the value; count hits, keep the first.
            S_SCAN:
            begin
                if (pend_reg && (mem_rdata == val_reg))
                begin
                    cnt_next = cnt_reg + LW'(1);
                    if (!hit_reg)
                    begin
                        hit_next  = 1'b1;
                        fidx_next = ptr_m1[AW-1:0];
                    end
                end
                if (ptr_reg < len_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg[AW-1:0];
                    ptr_next  = ptr_p1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (walk_done && (op_reg == FN_INDEX) && !hit_reg)
                begin
                    status_next = ST_NOTFOUND;
                end
            end

            // Reverse: finish the previous swap and read the low entry.
            S_REV_LO:
            begin
                if (wpend_reg)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = whi_reg;
                    mem_wdata  = tmp_reg;
                    wpend_next = 1'b0;
                end
                if (rev_more)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = lo_reg;
                end
            end

            // Hold the low entry and read the high one.
            S_REV_HI:
            begin
                tmp_next  = mem_rdata;
                mem_re    = 1'b1;
                mem_raddr = hi_reg;
            end

            // Write the high entry low and step both ends inwards.
            S_REV_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = lo_reg;
                mem_wdata  = mem_rdata;
                whi_next   = hi_reg;
                wpend_next = 1'b1;
                lo_next    = lo_reg + AW'(1);
                hi_next    = hi_reg - AW'(1);
            end

            S_FINISH:
            begin
                res_valid = 1'b1;
            end

            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Result fields; search outputs show only for their own operation.
    always_comb
    begin
        res.status      = status_reg;
        res.read_value  = rd_reg;
        res.found_index = (op_reg == FN_INDEX) ? fidx_c[2:0] : 3'd0;
        res.match_count = (op_reg == FN_COUNT) ? cnt_c[3:0] : 4'd0;
        res.list_length = len_c[3:0];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            pend_reg  <= 1'b0;
            wpend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            pend_reg  <= pend_next;
            wpend_reg <= wpend_next;
        end
    end

    // Operands, pointers and result payload.
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        op_reg     <= op_next;
        val_reg    <= val_next;
        pos_reg    <= pos_next;
        ptr_reg    <= ptr_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        whi_reg    <= whi_next;
        tmp_reg    <= tmp_next;
        hit_reg    <= hit_next;
        fidx_reg   <= fidx_next;
        cnt_reg    <= cnt_next;
        rd_reg     <= rd_next;
    end

endmodule

`default_nettype wire

### sv/bounded_array_list_engine_unit.sv
// Bounded ordered list of signed 32-bit values, CAPACITY entries deep.
// Requests arrive on the req channel (func, item_value, position); each
// request gives exactly one result on the rsp channel (status, read_value,
// found_index, match_count, list_length). A transaction completes at a
// rising edge of clk with valid and ready both high.
// Entries live in a RAM with one write and one registered read port; the
// sequencer handles one request at a time and shifts, scans or swaps
// entries through the RAM's read and write ports.
// A finished result sits in an output register, so the next request is taken
// while the receiver still stalls; a further result waits in the sequencer
// until that register frees.
// Reset (rst_n low, asynchronous) empties the list and drops any pending
// result; entry contents are not cleared, as nothing past the length is read.
`default_nettype none

`include "bounded_array_list_engine_unit_assert.svh"

module bounded_array_list_engine_unit
    import bale_pkg::*;
#(
    parameter int CAPACITY = 8
) (
    input wire logic   clk,
    input wire logic   rst_n,
    bale_req_if.sink   req,
    bale_rsp_if.source rsp
);

    localparam int AW = $clog2(CAPACITY > 1 ? CAPACITY : 2);

    bale_req_t     req_s;
    bale_result_t  res;
    logic          res_valid;
    logic          res_ready;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;
    logic          out_valid_reg;
    bale_result_t  out_data_reg;

    // Gather the request fields.
    always_comb
    begin
        req_s.func       = bale_func_t'(req.func);
        req_s.item_value = req.item_value;
        req_s.position   = req.position;
    end

    bale_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_s),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    bale_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register: takes a result whenever it is empty or being drained.
    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_data_reg.status;
    assign rsp.read_value  = out_data_reg.read_value;
    assign rsp.found_index = out_data_reg.found_index;
    assign rsp.match_count = out_data_reg.match_count;
    assign rsp.list_length = out_data_reg.list_length;

    // A request is never taken while the sequencer is offering a result.
    `BALE_ASSERT_SAME(a_no_accept_while_done, req.valid && req.ready, !res_valid,
        "request accepted while a result was pending")
    // Once a result moves to the output register the sequencer is free again.
    `BALE_ASSERT_NEXT(a_ready_after_result, res_valid && res_ready, req.ready,
        "sequencer not ready after handing over a result")
    // Only a successful extract returns a value.
    `BALE_ASSERT_SAME(a_value_only_on_ok, rsp.valid && (rsp.status != ST_OK),
        rsp.read_value == 32'sd0, "non-zero read value on a failed operation")

endmodule

`default_nettype wire
